// ----- rtl/toroidal_bearing_angle_core_defines.svh -----
// assertion macros for the checker file
`ifndef TOROIDAL_BEARING_ANGLE_CORE_DEFINES_SVH
`define TOROIDAL_BEARING_ANGLE_CORE_DEFINES_SVH

// same-cycle implication, quiet while reset is low
`define TBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tba: implication failed");

// implication with a fixed cycle delay, quiet while reset is low
`define TBA_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("tba: delayed implication failed");

// next-cycle implication, also checked during reset
`define TBA_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tba: next-cycle implication failed");

`endif

// ----- rtl/tba_pkg.sv -----
// shared types and constants of the toroidal bearing angle core
`default_nettype none
package tba_pkg;

    // configuration register file
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     MAP_SIZE_RESET = 24'h100000;

    // cordic datapath
    localparam int TABLE_LEN  = 24;
    localparam int PHASE_W    = 32;
    localparam int NORM_EXP   = 40;  // vectors are scaled so the larger side is >= 2^40
    localparam int SHIFT_W    = 6;
    localparam int DP_W       = 45;
    localparam int PRE_STAGES = 5;   // pipeline depth ahead of the first cell

    // atan(2^-i), 2^32 per full turn
    localparam logic [PHASE_W-1:0] ARC_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // one word moving down the cell chain
    typedef struct packed {
        logic                     valid;
        logic                     zero;
        logic signed [DP_W-1:0]   x;
        logic signed [DP_W-1:0]   y;
        logic [PHASE_W-1:0]       z;
    } t_cordic_word;

endpackage
`default_nettype wire

// ----- rtl/tba_prep.sv -----
// front end: wrapped differences, half-plane fold and normalization
`default_nettype none
module tba_prep
    import tba_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [COORD_BITS-1:0] i_from_x,
    input  wire logic [COORD_BITS-1:0] i_from_y,
    input  wire logic [COORD_BITS-1:0] i_to_x,
    input  wire logic [COORD_BITS-1:0] i_to_y,
    input  wire logic [CFG_W-1:0]      i_map_width,
    input  wire logic [CFG_W-1:0]      i_map_height,
    output t_cordic_word               o_word
);

    localparam int C = COORD_BITS;

    // one wrap correction, applied at most once
    function automatic logic signed [C:0] wrap_axis(input logic signed [C:0] d,
                                                    input logic [C-1:0] s);
        logic signed [C+1:0] d2;
        logic signed [C+1:0] s2;
        logic signed [C+1:0] res;
        d2  = {d, 1'b0};
        s2  = $signed({2'b00, s});
        res = (C+2)'(d);
        if (d2 > s2) begin
            res = (C+2)'(d) - s2;
        end else if (d2 < -s2) begin
            res = (C+2)'(d) + s2;
        end
        return res[C:0];
    endfunction

    logic                  r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [C:0]     r1_dx, r1_dy, r2_dx, r2_dy;
    logic                  r3_zero, r3_neg, r4_zero, r4_neg;
    logic [C-1:0]          r3_x, r4_x;
    logic signed [C:0]     r3_y, r4_y;
    logic [SHIFT_W-1:0]    r4_k;
    logic                  r5_zero;
    logic signed [DP_W-1:0] r5_x;
    logic signed [DP_W-1:0] r5_y;
    logic [PHASE_W-1:0]    r5_z;

    logic [C-1:0]          n_ay;
    logic [C-1:0]          n_mag;
    logic [SHIFT_W-1:0]    n_pos;
    logic signed [C:0]     n_fx;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    // raw differences, then the wrap
    always_ff @(posedge i_clk) begin
        r1_dx <= $signed({1'b0, i_to_x}) - $signed({1'b0, i_from_x});
        r1_dy <= $signed({1'b0, i_to_y}) - $signed({1'b0, i_from_y});
        r2_dx <= wrap_axis(r1_dx, C'(i_map_width));
        r2_dy <= wrap_axis(r1_dy, C'(i_map_height));
    end

    // fold into the right half plane
    assign n_fx = r2_dx[C] ? -r2_dx : r2_dx;

    always_ff @(posedge i_clk) begin
        r3_zero <= (r2_dx == '0) && (r2_dy == '0);
        r3_neg  <= r2_dx[C];
        r3_x    <= n_fx[C-1:0];
        r3_y    <= r2_dx[C] ? -r2_dy : r2_dy;
    end

    // leading one of the larger side gives the scale shift
    always_comb begin
        n_ay  = r3_y[C] ? C'(-r3_y) : r3_y[C-1:0];
        n_mag = (r3_x > n_ay) ? r3_x : n_ay;
        n_pos = '0;
        for (int i = 0; i < C; i++) begin
            if (n_mag[i]) begin
                n_pos = SHIFT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r4_zero <= r3_zero;
        r4_neg  <= r3_neg;
        r4_x    <= r3_x;
        r4_y    <= r3_y;
        r4_k    <= SHIFT_W'(NORM_EXP) - n_pos;
    end

    // scaled vector and starting phase
    always_ff @(posedge i_clk) begin
        r5_zero <= r4_zero;
        r5_x    <= $signed(DP_W'(r4_x)) <<< r4_k;
        r5_y    <= DP_W'(r4_y) <<< r4_k;
        r5_z    <= {r4_neg, {(PHASE_W-1){1'b0}}};
    end

    assign o_word = '{valid: r5_v, zero: r5_zero, x: r5_x, y: r5_y, z: r5_z};

endmodule
`default_nettype wire

// ----- rtl/tba_cell.sv -----
// one vectoring rotation of the cordic chain
`default_nettype none
module tba_cell
    import tba_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cordic_word i_word,
    output t_cordic_word      o_word
);

    logic signed [DP_W-1:0] n_xs;
    logic signed [DP_W-1:0] n_ys;
    logic                   r_valid;
    logic                   r_zero;
    logic signed [DP_W-1:0] r_x;
    logic signed [DP_W-1:0] r_y;
    logic [PHASE_W-1:0]     r_z;

    assign n_xs = i_word.x >>> STAGE;
    assign n_ys = i_word.y >>> STAGE;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_word.valid;
        end
    end

    // rotate toward the x axis, steering by the sign of y
    always_ff @(posedge i_clk) begin
        r_zero <= i_word.zero;
        if (!i_word.y[DP_W-1]) begin
            r_x <= i_word.x + n_ys;
            r_y <= i_word.y - n_xs;
            r_z <= i_word.z + ARC_TABLE[STAGE];
        end else begin
            r_x <= i_word.x - n_ys;
            r_y <= i_word.y + n_xs;
            r_z <= i_word.z - ARC_TABLE[STAGE];
        end
    end

    assign o_word = '{valid: r_valid, zero: r_zero, x: r_x, y: r_y, z: r_z};

endmodule
`default_nettype wire

// ----- rtl/toroidal_bearing_angle_core.sv -----
// top level of the toroidal bearing angle core
// Bearing from a start point to a target point on a map that wraps in x and y.
// One point pair is taken in every clock cycle (busy is high only in reset and
// the cycle after it). Each result is shown for one cycle with o_valid high,
// after passing the five front-end stages (difference, wrap, fold,
// leading-one search, scaling), one register per cordic cell, and the rounding
// register. The receiver cannot stall the core, so a result must be taken in
// the cycle it is shown. The user must write map sizes through the cfg port
// only while no pair is in flight; the core itself does not enforce this.
`default_nettype none
module toroidal_bearing_angle_core
    import tba_pkg::*;
#(
    parameter int COORD_BITS    = 24,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [COORD_BITS-1:0]        i_from_x,
    input  wire logic [COORD_BITS-1:0]        i_from_y,
    input  wire logic [COORD_BITS-1:0]        i_to_x,
    input  wire logic [COORD_BITS-1:0]        i_to_y,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]             i_cfg_data,
    output logic                              o_valid,
    output logic signed [ANGLE_BITS-1:0]      o_bearing
);

    localparam int N_CELLS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam logic [PHASE_W-1:0] ROUND_HALF = PHASE_W'(1) << (PHASE_W - 1 - ANGLE_BITS);

    logic                          r_busy;
    logic [CFG_W-1:0]              r_map_width;
    logic [CFG_W-1:0]              r_map_height;
    logic                          r_valid;
    logic signed [ANGLE_BITS-1:0]  r_bearing;
    logic                          n_accept;
    logic [PHASE_W-1:0]            n_sum;
    t_cordic_word                  w_chain [N_CELLS+1];

    assign n_accept = start && !r_busy;

    // busy holds off words until reset has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // map size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= MAP_SIZE_RESET;
            r_map_height <= MAP_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end
    tba_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (n_accept),
        .i_from_x     (i_from_x),
        .i_from_y     (i_from_y),
        .i_to_x       (i_to_x),
        .i_to_y       (i_to_y),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .o_word       (w_chain[0])
    );

    // cordic cell chain
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        tba_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    // round the phase to the output angle width
    assign n_sum = w_chain[N_CELLS].z + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_chain[N_CELLS].valid;
        end
        r_bearing <= w_chain[N_CELLS].zero ? '0 :
                     $signed(n_sum[PHASE_W-1 -: ANGLE_BITS]);
    end

    assign busy      = r_busy;
    assign o_valid   = r_valid;
    assign o_bearing = r_bearing;

endmodule
`default_nettype wire

// ----- rtl/tba_checker.sv -----
// port-level checker for the toroidal bearing angle core, with its bind
`default_nettype none
`include "toroidal_bearing_angle_core_defines.svh"
module tba_checker
    import tba_pkg::*;
#(
    parameter int COORD_BITS    = 24,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic [COORD_BITS-1:0]        i_from_x,
    input wire logic [COORD_BITS-1:0]        i_from_y,
    input wire logic [COORD_BITS-1:0]        i_to_x,
    input wire logic [COORD_BITS-1:0]        i_to_y,
    input wire logic                         o_valid,
    input wire logic signed [ANGLE_BITS-1:0] o_bearing
);

    localparam int LATENCY = ((CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN)
                             + PRE_STAGES + 1;

    logic w_accept;
    logic w_same;

    assign w_accept = start && !busy;
    assign w_same   = (i_from_x == i_to_x) && (i_from_y == i_to_y);

    // every accepted word yields a strobe after the fixed latency
    `TBA_ASSERT_DLY(a_word_out, i_clk, i_rst_n, w_accept, LATENCY, o_valid)

    // no strobe without a word accepted that long ago
    `TBA_ASSERT_NOW(a_no_extra, i_clk, i_rst_n, o_valid, $past(w_accept, LATENCY))

    // identical points give a zero bearing
    `TBA_ASSERT_DLY(a_same_zero, i_clk, i_rst_n, w_accept && w_same, LATENCY, o_bearing == '0)

    // reset empties the pipe and blocks new words
    `TBA_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_valid && busy)

endmodule

bind toroidal_bearing_angle_core tba_checker #(
    .COORD_BITS    (COORD_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
) u_tba_checker (.*);
`default_nettype wire
